// ----- hdl/aib_pkg.sv -----
// Package for the activity intensity binner: field types, register codes and helpers.
`default_nettype none

package aib_pkg;

  // Field widths
  localparam int COUNT_W    = 16;
  localparam int MINUTE_W   = 20;
  localparam int SUM_W      = COUNT_W + MINUTE_W;
  localparam int CUT_W      = 16;
  localparam int GROUP_W    = 3;
  localparam int LEVELS     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [GROUP_W-1:0]   group_t;

  // Register indexes
  localparam cfg_idx_t REG_CUT_1 = 3'd0;
  localparam cfg_idx_t REG_CUT_2 = 3'd1;
  localparam cfg_idx_t REG_CUT_3 = 3'd2;
  localparam cfg_idx_t REG_CUT_4 = 3'd3;

  // Register reset values
  localparam logic [CUT_W-1:0] CUT_1_RST = 16'd100;
  localparam logic [CUT_W-1:0] CUT_2_RST = 16'd760;
  localparam logic [CUT_W-1:0] CUT_3_RST = 16'd2020;
  localparam logic [CUT_W-1:0] CUT_4_RST = 16'd5999;

  // Combined group codes; codes below GROUP_LVL23 are single levels
  localparam group_t GROUP_LVL23 = 3'd5;
  localparam group_t GROUP_LVL45 = 3'd6;
  localparam group_t GROUP_LAST  = 3'd7;

  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic               end_of_record;
  } in_word_t;

  typedef struct packed {
    group_t              group_index;
    logic [MINUTE_W-1:0] minutes;
    logic [SUM_W-1:0]    count_sum;
    logic                last_group;
  } out_word_t;

  typedef struct packed {
    logic [CUT_W-1:0] cut_1;
    logic [CUT_W-1:0] cut_2;
    logic [CUT_W-1:0] cut_3;
    logic [CUT_W-1:0] cut_4;
  } cuts_t;

  // Control from the input stage to the tally block
  typedef struct packed {
    logic take;
    logic end_of_record;
  } step_t;

  typedef logic [LEVELS-1:0][MINUTE_W-1:0] level_min_t;
  typedef logic [LEVELS-1:0][SUM_W-1:0]    level_sum_t;

  function automatic logic [MINUTE_W-1:0] sat_add_min(input logic [MINUTE_W-1:0] a,
                                                      input logic [MINUTE_W-1:0] b);
    logic [MINUTE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MINUTE_W] ? {MINUTE_W{1'b1}} : s[MINUTE_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add_sum(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // First test that holds picks the level; no bit set when none holds
  function automatic logic [LEVELS-1:0] classify(input logic [COUNT_W-1:0] c,
                                                 input cuts_t cuts);
    logic [LEVELS-1:0] hit;
    hit    = '0;
    hit[0] = (c < cuts.cut_1);
    hit[1] = !hit[0] && (c >= cuts.cut_1) && (c < cuts.cut_2);
    hit[2] = !(hit[0] || hit[1]) && (c >= cuts.cut_2) && (c < cuts.cut_3);
    hit[3] = !(hit[0] || hit[1] || hit[2]) && (c >= cuts.cut_3) && (c < cuts.cut_4);
    hit[4] = !(hit[0] || hit[1] || hit[2] || hit[3]) && (c >= cuts.cut_4);
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/activity_intensity_binner.sv -----
// Top level of the activity intensity binner.
`default_nettype none

// Bins one count word per cycle into five intensity levels set by four cutpoint
// registers, keeping a saturating minute tally and count sum per level. A word
// is taken every cycle unless in_stall is high; it is classified and added as
// it leaves the input register. A word marked end of record closes the
// record: its tallies move into a snapshot and clear, and eight result words
// follow, one per cycle the output side takes (levels 1 to 5, then levels 2-3,
// 4-5 and 2-5, the last flagged). Words of the next record keep flowing during
// the readout; a second end-of-record word waits in the input register until
// the eighth result of the previous readout has been loaded into the output
// register. Write the cutpoints only while the block is idle.
module activity_intensity_binner (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire aib_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output aib_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_wr_en,
  input  wire aib_pkg::cfg_idx_t              cfg_index,
  input  wire logic [aib_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aib_pkg::*;

  cuts_t      cuts_r;
  logic       s1_valid_r, s1_valid_nxt;
  in_word_t   s1_word_r;
  logic       s1_hold, s1_take, in_accept;
  step_t      step;
  level_min_t snap_min;
  level_sum_t snap_sum;
  logic       busy_r, busy_nxt;
  group_t     rd_idx_r, rd_idx_nxt;
  logic       out_load;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  logic [MINUTE_W-1:0] c23_min_r, c45_min_r, call_min_r;
  logic [SUM_W-1:0]    c23_sum_r, c45_sum_r, call_sum_r;

  // Cutpoint registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cuts_r.cut_1 <= CUT_1_RST;
      cuts_r.cut_2 <= CUT_2_RST;
      cuts_r.cut_3 <= CUT_3_RST;
      cuts_r.cut_4 <= CUT_4_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CUT_1: cuts_r.cut_1 <= cfg_data;
        REG_CUT_2: cuts_r.cut_2 <= cfg_data;
        REG_CUT_3: cuts_r.cut_3 <= cfg_data;
        REG_CUT_4: cuts_r.cut_4 <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Input register; hold an end-of-record word while the snapshot is in use
  assign s1_hold   = s1_valid_r && s1_word_r.end_of_record && busy_r;
  assign s1_take   = s1_valid_r && !s1_hold;
  assign in_stall  = s1_hold;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_accept || s1_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_data;
    end
  end

  assign step.take          = s1_take;
  assign step.end_of_record = s1_word_r.end_of_record;

  aib_tally u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .count    (s1_word_r.sample_count),
    .cuts     (cuts_r),
    .snap_min (snap_min),
    .snap_sum (snap_sum)
  );

  // Combined groups from the snapshot; ready well before their turn in readout
  always_ff @(posedge clk) begin
    c23_min_r  <= sat_add_min(snap_min[1], snap_min[2]);
    c23_sum_r  <= sat_add_sum(snap_sum[1], snap_sum[2]);
    c45_min_r  <= sat_add_min(snap_min[3], snap_min[4]);
    c45_sum_r  <= sat_add_sum(snap_sum[3], snap_sum[4]);
    call_min_r <= sat_add_min(c23_min_r, c45_min_r);
    call_sum_r <= sat_add_sum(c23_sum_r, c45_sum_r);
  end

  // Readout sequencing: load one group per free output slot
  assign out_load = busy_r && (!out_valid_r || !out_stall);

  always_comb begin
    busy_nxt   = busy_r;
    rd_idx_nxt = rd_idx_r;
    if (out_load) begin
      rd_idx_nxt = rd_idx_r + 3'd1;
      if (rd_idx_r == GROUP_LAST) begin
        busy_nxt = 1'b0;
      end
    end
    if (s1_take && s1_word_r.end_of_record) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // Select the group word to load
  always_comb begin
    out_word_nxt.group_index = rd_idx_r;
    out_word_nxt.last_group  = (rd_idx_r == GROUP_LAST);
    if (rd_idx_r == GROUP_LVL23) begin
      out_word_nxt.minutes   = c23_min_r;
      out_word_nxt.count_sum = c23_sum_r;
    end else if (rd_idx_r == GROUP_LVL45) begin
      out_word_nxt.minutes   = c45_min_r;
      out_word_nxt.count_sum = c45_sum_r;
    end else if (rd_idx_r == GROUP_LAST) begin
      out_word_nxt.minutes   = call_min_r;
      out_word_nxt.count_sum = call_sum_r;
    end else begin
      out_word_nxt.minutes   = snap_min[rd_idx_r];
      out_word_nxt.count_sum = snap_sum[rd_idx_r];
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// ----- hdl/aib_tally.sv -----
// Per-level minute tallies and count sums, with a snapshot taken at each end of record.
`default_nettype none

module aib_tally (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire aib_pkg::step_t              step,
  input  wire logic [aib_pkg::COUNT_W-1:0] count,
  input  wire aib_pkg::cuts_t              cuts,
  output aib_pkg::level_min_t              snap_min,
  output aib_pkg::level_sum_t              snap_sum
);
  import aib_pkg::*;

  level_min_t        tally_min_r, tally_min_nxt;
  level_sum_t        tally_sum_r, tally_sum_nxt;
  level_min_t        snap_min_r;
  level_sum_t        snap_sum_r;
  logic [LEVELS-1:0] hit;

  assign hit = classify(count, cuts);

  // Add the word into the level it falls in
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      if (hit[i]) begin
        tally_min_nxt[i] = sat_add_min(tally_min_r[i], MINUTE_W'(1));
        tally_sum_nxt[i] = sat_add_sum(tally_sum_r[i], SUM_W'(count));
      end else begin
        tally_min_nxt[i] = tally_min_r[i];
        tally_sum_nxt[i] = tally_sum_r[i];
      end
    end
  end

  // Advance tallies; on end of record copy them out and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_min_r <= '0;
      tally_sum_r <= '0;
    end else if (step.take) begin
      if (step.end_of_record) begin
        tally_min_r <= '0;
        tally_sum_r <= '0;
      end else begin
        tally_min_r <= tally_min_nxt;
        tally_sum_r <= tally_sum_nxt;
      end
    end
  end

  // Snapshot holds the closed record for readout
  always_ff @(posedge clk) begin
    if (step.take && step.end_of_record) begin
      snap_min_r <= tally_min_nxt;
      snap_sum_r <= tally_sum_nxt;
    end
  end

  assign snap_min = snap_min_r;
  assign snap_sum = snap_sum_r;

endmodule

`default_nettype wire

// ----- hdl/aib_checker.sv -----
// Port-level checker for the activity intensity binner, with its bind.
`default_nettype none

module aib_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire aib_pkg::out_word_t out_data
);
  import aib_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // Readout runs through the groups in order without gaps
  a_group_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_group |=>
      out_valid && (out_data.group_index == $past(out_data.group_index) + 3'd1))
    else $error("readout group out of sequence");

  // Last flag marks exactly the final group
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_group == (out_data.group_index == GROUP_LAST)))
    else $error("last flag does not match final group");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind activity_intensity_binner aib_checker u_aib_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
